// File: hdl/sff_pkg.sv
// ----------------------------------------------------------------------------
// sff_pkg: shared types and codes of the span flood fill block
// Request and status codes, sequencer states and the span queue entry layout.
// ----------------------------------------------------------------------------
package sff_pkg;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;
    localparam int COORD_W     = 8;
    localparam int OUT_COLOR_W = 15;
    localparam int COUNT_W     = 16;
    localparam int SPAN_W      = 25;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_FILL  = 2'd2;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_SAME = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_WAIT  = 10'b00_0000_0010,
        S_EVAL  = 10'b00_0000_0100,
        S_INIT2 = 10'b00_0000_1000,
        S_QPOP  = 10'b00_0001_0000,
        S_QLOAD = 10'b00_0010_0000,
        S_MLOOP = 10'b00_0100_0000,
        S_POST1 = 10'b00_1000_0000,
        S_POST2 = 10'b01_0000_0000,
        S_SCAN  = 10'b10_0000_0000
    } state_t;

    // what the pixel probe result is used for
    typedef enum logic [2:0] {
        EV_READ,
        EV_SEED,
        EV_LEFT0,
        EV_LEFT,
        EV_PAINT,
        EV_SKIP
    } probe_t;

    typedef struct packed {
        logic                  down;
        logic [COORD_W-1:0]    row;
        logic [COORD_W-1:0]    x2;
        logic [COORD_W-1:0]    x1;
    } span_t;

endpackage

// File: hdl/sff_ram.sv
// ----------------------------------------------------------------------------
// sff_ram: generic single-clock RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sff_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 38400
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/span_flood_fill.sv
// ----------------------------------------------------------------------------
// span_flood_fill: frame store with pixel access and 4-connected span fill
// Each transaction on the slave side writes a pixel, reads a pixel or flood
// fills from a seed; one result transaction follows each request. A write,
// an unknown request or an out-of-range position answers the cycle after it
// is taken. A read, or a fill whose seed already has the fill colour,
// answers after the probe states S_WAIT and S_EVAL. A fill runs a scanline
// span fill over a FIFO of pending spans. Every pixel probe passes S_WAIT,
// which puts the address on the shared frame store port, and S_EVAL,
// which uses the registered read data. Painting adds no state, because the
// write goes out in the cycle that evaluates the probe. Each popped span
// goes through S_QPOP and S_QLOAD for queue access, and each painted run
// through S_POST1, S_POST2, S_SCAN and S_MLOOP for loop and push overhead.
// No new request is taken until the result of the previous one has been
// delivered. A full span queue ends the fill with an overflow status.
// ----------------------------------------------------------------------------
module span_flood_fill #(
    parameter int IMG_WIDTH   = 240,
    parameter int IMG_HEIGHT  = 160,
    parameter int QUEUE_DEPTH = 128,
    parameter int COLOR_BITS  = 15
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // req_type[1:0], pos_x[9:2], pos_y[17:10], pixel_color[32:18], zero fill
    input  logic [sff_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // read_color[14:0], status[16:15], painted_count[32:17], zero fill
    output logic [sff_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    import sff_pkg::*;

    localparam int FDEPTH = IMG_WIDTH * IMG_HEIGHT;
    localparam int AW     = $clog2(FDEPTH);
    localparam int QW     = $clog2(QUEUE_DEPTH);
    localparam int CW     = $clog2(QUEUE_DEPTH + 1);
    localparam logic [COORD_W-1:0] W8 = COORD_W'(IMG_WIDTH);
    localparam logic [COORD_W-1:0] H8 = COORD_W'(IMG_HEIGHT);
    localparam logic [CW-1:0]      QFULL = CW'(QUEUE_DEPTH);
    localparam logic [QW-1:0]      QLAST = QW'(QUEUE_DEPTH - 1);

    state_t                  state_reg, state_next;
    probe_t                  ev_reg, ev_next;
    logic signed [9:0]       pc_x_reg, pc_x_next;
    logic [COORD_W-1:0]      pc_row_reg, pc_row_next;
    logic                    inr_reg, inr_next;
    logic [COLOR_BITS-1:0]   old_reg, old_next;
    logic [COLOR_BITS-1:0]   new_reg, new_next;
    logic signed [9:0]       x_reg, x_next;
    logic signed [9:0]       x1_reg, x1_next;
    logic signed [9:0]       x2_reg, x2_next;
    logic [COORD_W-1:0]      row_reg, row_next;
    logic                    down_reg, down_next;
    logic [QW-1:0]           head_reg, head_next;
    logic [QW-1:0]           tail_reg, tail_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [COUNT_W-1:0]      painted_reg, painted_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;

    logic [1:0]              in_req;
    logic [COORD_W-1:0]      in_x, in_y;
    logic [OUT_COLOR_W-1:0]  in_color;
    logic                    in_range, s_acc, pc_inr, match;
    logic [COORD_W-1:0]      am_x, am_row;
    logic [AW-1:0]           f_addr;
    logic                    f_we, f_re;
    logic [COLOR_BITS-1:0]   f_wdata, f_rd;
    logic                    q_we, q_re, q_clear;
    span_t                   push_word, q_rd;
    logic                    push_en;
    logic                    out_load;
    logic [OUT_COLOR_W-1:0]  out_color;
    logic [1:0]              out_status;
    logic [COUNT_W-1:0]      out_count;
    logic [COORD_W-1:0]      row_fwd, row_back;
    logic [15:0]             addr_full;

    assign in_req   = s_tdata[1:0];
    assign in_x     = s_tdata[9:2];
    assign in_y     = s_tdata[17:10];
    assign in_color = s_tdata[32:18];
    assign in_range = (in_x < W8) && (in_y < H8);

    assign s_tready = (state_reg == S_IDLE) && !m_tvalid_reg;
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign pc_inr = !pc_x_reg[9] && (pc_x_reg[8:0] < {1'b0, W8}) && (pc_row_reg < H8);
    assign match  = inr_reg && (f_rd == old_reg);

    assign row_fwd  = down_reg ? row_reg + 8'd1 : row_reg - 8'd1;
    assign row_back = down_reg ? row_reg - 8'd1 : row_reg + 8'd1;

    assign addr_full = {8'd0, am_row} * {8'd0, W8} + {8'd0, am_x};
    assign f_addr    = addr_full[AW-1:0];

    sff_ram #(
        .WIDTH (COLOR_BITS),
        .DEPTH (FDEPTH)
    ) u_frame (
        .clk     (aclk),
        .wr_en   (f_we),
        .wr_addr (f_addr),
        .wr_data (f_wdata),
        .rd_en   (f_re),
        .rd_addr (f_addr),
        .rd_data (f_rd)
    );

    sff_ram #(
        .WIDTH (SPAN_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (aclk),
        .wr_en   (q_we),
        .wr_addr (tail_reg),
        .wr_data (push_word),
        .rd_en   (q_re),
        .rd_addr (head_reg),
        .rd_data (q_rd)
    );

    always_comb begin
        state_next    = state_reg;
        ev_next       = ev_reg;
        pc_x_next     = pc_x_reg;
        pc_row_next   = pc_row_reg;
        inr_next      = inr_reg;
        old_next      = old_reg;
        new_next      = new_reg;
        x_next        = x_reg;
        x1_next       = x1_reg;
        x2_next       = x2_reg;
        row_next      = row_reg;
        down_next     = down_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        painted_next  = painted_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        am_x          = pc_x_reg[7:0];
        am_row        = pc_row_reg;
        f_we          = 1'b0;
        f_re          = 1'b0;
        f_wdata       = new_reg;
        q_we          = 1'b0;
        q_re          = 1'b0;
        q_clear       = 1'b0;
        push_en       = 1'b0;
        push_word     = '0;
        out_load      = 1'b0;
        out_color     = '0;
        out_status    = ST_DONE;
        out_count     = '0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                am_x   = in_x;
                am_row = in_y;
                if (s_acc) begin
                    case (in_req)
                        REQ_WRITE: begin
                            f_we     = in_range;
                            f_wdata  = COLOR_BITS'(in_color);
                            out_load = 1'b1;
                        end
                        REQ_READ: begin
                            if (in_range) begin
                                pc_x_next   = {2'b00, in_x};
                                pc_row_next = in_y;
                                ev_next     = EV_READ;
                                state_next  = S_WAIT;
                            end else begin
                                out_load = 1'b1;
                            end
                        end
                        REQ_FILL: begin
                            if (in_range) begin
                                pc_x_next   = {2'b00, in_x};
                                pc_row_next = in_y;
                                new_next    = COLOR_BITS'(in_color);
                                ev_next     = EV_SEED;
                                state_next  = S_WAIT;
                            end else begin
                                out_load = 1'b1;
                            end
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_WAIT: begin
                f_re       = 1'b1;
                inr_next   = pc_inr;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                case (ev_reg)
                    EV_READ: begin
                        out_load   = 1'b1;
                        out_color  = OUT_COLOR_W'(f_rd);
                        state_next = S_IDLE;
                    end
                    EV_SEED: begin
                        old_next = f_rd;
                        if (f_rd == new_reg) begin
                            out_load   = 1'b1;
                            out_status = ST_SAME;
                            state_next = S_IDLE;
                        end else begin
                            painted_next = '0;
                            push_en      = 1'b1;
                            push_word    = '{down: 1'b1, row: pc_row_reg,
                                             x2: pc_x_reg[7:0], x1: pc_x_reg[7:0]};
                            state_next   = S_INIT2;
                        end
                    end
                    EV_LEFT0: begin
                        if (match) begin
                            pc_x_next  = x_reg - 10'sd1;
                            ev_next    = EV_LEFT;
                            state_next = S_WAIT;
                        end else begin
                            state_next = S_MLOOP;
                        end
                    end
                    EV_LEFT: begin
                        if (match) begin
                            f_we         = 1'b1;
                            painted_next = painted_reg + 16'd1;
                            x_next       = x_reg - 10'sd1;
                            pc_x_next    = pc_x_reg - 10'sd1;
                            state_next   = S_WAIT;
                        end else begin
                            if (x_reg < x1_reg) begin
                                push_en   = 1'b1;
                                push_word = '{down: !down_reg, row: row_back,
                                              x2: 8'(x1_reg - 10'sd1), x1: x_reg[7:0]};
                            end
                            state_next = S_MLOOP;
                        end
                    end
                    EV_PAINT: begin
                        if (match) begin
                            f_we         = 1'b1;
                            painted_next = painted_reg + 16'd1;
                            x1_next      = x1_reg + 10'sd1;
                            pc_x_next    = x1_reg + 10'sd1;
                            state_next   = S_WAIT;
                        end else begin
                            state_next = S_POST1;
                        end
                    end
                    EV_SKIP: begin
                        if (match) begin
                            x_next     = x1_reg;
                            state_next = S_MLOOP;
                        end else begin
                            x1_next    = x1_reg + 10'sd1;
                            state_next = S_SCAN;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_INIT2: begin
                push_en    = 1'b1;
                push_word  = '{down: 1'b0, row: pc_row_reg - 8'd1,
                               x2: pc_x_reg[7:0], x1: pc_x_reg[7:0]};
                state_next = S_QPOP;
            end
            S_QPOP: begin
                if (count_reg == '0) begin
                    out_load   = 1'b1;
                    out_count  = painted_reg;
                    q_clear    = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    q_re       = 1'b1;
                    head_next  = (head_reg == QLAST) ? '0 : head_reg + QW'(1);
                    count_next = count_reg - CW'(1);
                    state_next = S_QLOAD;
                end
            end
            S_QLOAD: begin
                x1_next     = {2'b00, q_rd.x1};
                x2_next     = {2'b00, q_rd.x2};
                x_next      = {2'b00, q_rd.x1};
                row_next    = q_rd.row;
                down_next   = q_rd.down;
                pc_x_next   = {2'b00, q_rd.x1};
                pc_row_next = q_rd.row;
                ev_next     = EV_LEFT0;
                state_next  = S_WAIT;
            end
            S_MLOOP: begin
                if (x1_reg <= x2_reg) begin
                    pc_x_next   = x1_reg;
                    pc_row_next = row_reg;
                    ev_next     = EV_PAINT;
                    state_next  = S_WAIT;
                end else begin
                    state_next = S_QPOP;
                end
            end
            S_POST1: begin
                if (x1_reg > x_reg) begin
                    push_en   = 1'b1;
                    push_word = '{down: down_reg, row: row_fwd,
                                  x2: 8'(x1_reg - 10'sd1), x1: x_reg[7:0]};
                end
                state_next = S_POST2;
            end
            S_POST2: begin
                if (x1_reg - 10'sd1 > x2_reg) begin
                    push_en   = 1'b1;
                    push_word = '{down: !down_reg, row: row_back,
                                  x2: 8'(x1_reg - 10'sd1), x1: 8'(x2_reg + 10'sd1)};
                end
                x1_next    = x1_reg + 10'sd1;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                if (x1_reg <= x2_reg) begin
                    pc_x_next   = x1_reg;
                    pc_row_next = row_reg;
                    ev_next     = EV_SKIP;
                    state_next  = S_WAIT;
                end else begin
                    x_next     = x1_reg;
                    state_next = S_MLOOP;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // a push into a full queue ends the fill
        if (push_en) begin
            if (count_reg == QFULL) begin
                out_load   = 1'b1;
                out_status = ST_OVF;
                out_count  = painted_reg;
                q_clear    = 1'b1;
                state_next = S_IDLE;
            end else begin
                q_we       = 1'b1;
                tail_next  = (tail_reg == QLAST) ? '0 : tail_reg + QW'(1);
                count_next = count_reg + CW'(1);
            end
        end

        if (q_clear) begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end

        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {7'd0, out_count, out_status, out_color};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ev_reg      <= ev_next;
        pc_x_reg    <= pc_x_next;
        pc_row_reg  <= pc_row_next;
        inr_reg     <= inr_next;
        old_reg     <= old_next;
        new_reg     <= new_next;
        x_reg       <= x_next;
        x1_reg      <= x1_next;
        x2_reg      <= x2_next;
        row_reg     <= row_next;
        down_reg    <= down_next;
        painted_reg <= painted_next;
        m_tdata_reg <= m_tdata_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QFULL)
        else $error("span queue count beyond depth");

    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (count_reg == '0 && head_reg == '0 && tail_reg == '0))
        else $error("span queue not empty between requests");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_tdata_reg[16:15] == ST_DONE || m_tdata_reg[16:15] == ST_SAME
                          || m_tdata_reg[16:15] == ST_OVF))
        else $error("invalid status code on result");

    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> m_tvalid_reg && $stable(m_tdata_reg))
        else $error("pending result lost");
`endif

endmodule

// File: verif/tb_span_flood_fill.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_span_flood_fill: self-checking bench for the span flood fill block
// Two pixel windows, one in the top-left and one in the bottom-right corner
// of the frame, are written in full and fenced by a border colour that no
// request ever writes or fills with, so no read or fill touches an unwritten
// pixel. A queue of requests is then streamed in: directed edge cases, a
// window fill, a comb pattern and random requests over small colour
// regions. Each accepted request is run through a local predictor of the
// frame and span queue, and every result is checked field by field.
// ----------------------------------------------------------------------------
module tb_span_flood_fill;

    import sff_pkg::*;

    localparam int W  = 240;
    localparam int H  = 160;
    localparam int QD = 128;
    localparam int WA = 24;
    localparam int HA = 16;
    localparam logic [14:0] BORDER     = 15'h7C00;
    localparam logic [1:0]  REQ_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [14:0] color;
    } req_item_t;

    typedef struct {
        logic [14:0] rd_color;
        logic [1:0]  status;
        logic [15:0] count;
    } fill_result_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    req_item_t    req_queue[$];
    fill_result_t pending_results[$];

    // predictor state: frame, span FIFO and the fill in progress
    logic [14:0] pix [0:W*H-1];
    span_t       spans [0:QD-1];
    int          sq_head, sq_tail, sq_count;
    logic [14:0] old_c, new_c;
    int          painted_n;

    int  fail_cnt  = 0;
    int  taken_cnt = 0;
    int  send_gap  = 0;
    int  hold_cnt  = 0;
    bit  pressure_done = 1'b0;
    logic [14:0] palette [0:3];

    span_flood_fill i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit is_old(int x, int r);
        if (x < 0 || r < 0 || x >= W || r >= H) return 1'b0;
        return pix[r*W + x] == old_c;
    endfunction

    function automatic bit span_push(int x1, int x2, int r, bit dn);
        if (sq_count >= QD) return 1'b0;
        spans[sq_tail] = span_t'{dn, r[7:0], x2[7:0], x1[7:0]};
        sq_tail = (sq_tail + 1) % QD;
        sq_count++;
        return 1'b1;
    endfunction

    function automatic logic [1:0] flood_predict(int sx, int sy);
        span_t e;
        int    x1, x2, r, x, dy;
        bit    dn;
        painted_n = 0;
        sq_head = 0; sq_tail = 0; sq_count = 0;
        void'(span_push(sx, sx, sy, 1'b1));
        void'(span_push(sx, sx, sy - 1, 1'b0));
        while (sq_count > 0) begin
            e = spans[sq_head];
            sq_head = (sq_head + 1) % QD;
            sq_count--;
            x1 = e.x1; x2 = e.x2; r = e.row; dn = e.down;
            dy = dn ? 1 : -1;
            x = x1;
            if (is_old(x, r)) begin
                while (is_old(x - 1, r)) begin
                    pix[r*W + x - 1] = new_c;
                    painted_n++;
                    x--;
                end
                if (x < x1 && !span_push(x, x1 - 1, r - dy, !dn)) return ST_OVF;
            end
            while (x1 <= x2) begin
                while (is_old(x1, r)) begin
                    pix[r*W + x1] = new_c;
                    painted_n++;
                    x1++;
                end
                if (x1 > x && !span_push(x, x1 - 1, r + dy, dn)) return ST_OVF;
                if (x1 - 1 > x2 && !span_push(x2 + 1, x1 - 1, r - dy, !dn)) return ST_OVF;
                x1++;
                while (x1 <= x2 && !is_old(x1, r)) x1++;
                x = x1;
            end
        end
        return ST_DONE;
    endfunction

    function automatic void predict_request(req_item_t q);
        fill_result_t res;
        bit in_range;
        res = '{15'd0, ST_DONE, 16'd0};
        in_range = q.x < W && q.y < H;
        if (q.kind == REQ_WRITE) begin
            if (in_range) pix[q.y*W + q.x] = q.color;
        end else if (q.kind == REQ_READ) begin
            if (in_range) res.rd_color = pix[q.y*W + q.x];
        end else if (q.kind == REQ_FILL) begin
            if (in_range) begin
                old_c = pix[q.y*W + q.x];
                new_c = q.color;
                if (old_c == new_c) begin
                    res.status = ST_SAME;
                end else begin
                    res.status = flood_predict(q.x, q.y);
                    res.count  = painted_n[15:0];
                end
            end
        end
        pending_results.insert(pending_results.size(), res);
    endfunction

    function automatic void add_req(logic [1:0] k, int x, int y, logic [14:0] c);
        req_item_t item;
        item = '{k, x[7:0], y[7:0], c};
        req_queue.insert(req_queue.size(), item);
    endfunction

    // driver: hold the offered transaction until it is taken
    always @(posedge aclk) begin : drive_proc
        logic                  nv;
        logic [IN_TDATA_W-1:0] nd;
        req_item_t             q;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            nv = s_tvalid;
            nd = s_tdata;
            if (s_tvalid && s_tready) begin
                predict_request(req_queue[0]);
                req_queue.delete(0);
                taken_cnt++;
                nv = 1'b0;
            end
            if (!nv && req_queue.size() > 0) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (req_queue.size() > 300 && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 2);
                end else begin
                    q  = req_queue[0];
                    nv = 1'b1;
                    nd = '0;
                    nd[32:0] = {q.color, q.y, q.x, q.kind};
                end
            end
            s_tvalid <= nv;
            s_tdata  <= nd;
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else if (!pressure_done && taken_cnt >= 900) begin
            pressure_done = 1'b1;
            hold_cnt = 399;
            m_tready <= 1'b0;
        end else if (req_queue.size() < 300) begin
            m_tready <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            hold_cnt = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // monitor: compare each result transaction with the oldest prediction
    always @(posedge aclk) begin : check_proc
        fill_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction %h", m_tdata);
                fail_cnt++;
            end else begin
                exp_r = pending_results[0];
                pending_results.delete(0);
                if (m_tdata[14:0] !== exp_r.rd_color) begin
                    $error("read_color exp %h got %h", exp_r.rd_color, m_tdata[14:0]);
                    fail_cnt++;
                end
                if (m_tdata[16:15] !== exp_r.status) begin
                    $error("status exp %0d got %0d", exp_r.status, m_tdata[16:15]);
                    fail_cnt++;
                end
                if (m_tdata[32:17] !== exp_r.count) begin
                    $error("painted_count exp %0d got %0d", exp_r.count, m_tdata[32:17]);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin : stim_proc
        int k, x, y, r;
        logic [14:0] c;
        for (int i = 0; i < 4; i++) palette[i] = {1'b0, 14'($urandom)};
        // clear both windows and fence them so no fill can leave them
        for (y = 0; y < HA; y++)
            for (x = 0; x < WA; x++) add_req(REQ_WRITE, x, y, 15'd0);
        for (y = 0; y <= HA; y++) add_req(REQ_WRITE, WA, y, BORDER);
        for (x = 0; x < WA; x++) add_req(REQ_WRITE, x, HA, BORDER);
        for (y = H-4; y < H; y++)
            for (x = W-4; x < W; x++) add_req(REQ_WRITE, x, y, 15'd0);
        for (y = H-5; y < H; y++) add_req(REQ_WRITE, W-5, y, BORDER);
        for (x = W-4; x < W; x++) add_req(REQ_WRITE, x, H-5, BORDER);
        add_req(REQ_READ, 0, 0, 15'h7FFF);
        add_req(REQ_WRITE, W-1, H-1, 15'h7FFF);
        add_req(REQ_READ, W-1, H-1, 15'd0);
        add_req(REQ_WRITE, WA-1, 0, 15'h5555);
        add_req(REQ_READ, WA-1, 0, 15'd0);
        add_req(REQ_WRITE, 0, HA-1, 15'h2AAA);
        add_req(REQ_READ, 0, HA-1, 15'd0);
        add_req(REQ_READ, WA, HA, 15'd0);
        add_req(REQ_WRITE, 240, 10, 15'h1234);
        add_req(REQ_WRITE, 10, 255, 15'h1234);
        add_req(REQ_READ, 255, 0, 15'd0);
        add_req(REQ_READ, 0, 160, 15'd0);
        add_req(REQ_FILL, 240, 0, 15'h0001);
        add_req(REQ_FILL, 0, 255, 15'h0001);
        add_req(REQ_UNUSED, 5, 5, 15'h7FFF);
        add_req(REQ_FILL, 5, 5, 15'd0);
        add_req(REQ_FILL, W-1, H-1, 15'd0);
        add_req(REQ_FILL, W-1, H-1, 15'h7FFF);
        add_req(REQ_WRITE, W-1, H-1, 15'd0);
        // fill from the center of the top-left window, sparing its two recoloured corners
        add_req(REQ_FILL, WA/2, HA/2, 15'h7FFF);
        add_req(REQ_READ, 0, 0, 15'd0);
        add_req(REQ_READ, W-1, H-1, 15'd0);
        // comb on top rows, random small regions below
        for (y = 0; y < HA; y++)
            for (x = 0; x < WA; x++) begin
                if (y < 6) c = (y == 0 || x % 2 == 0) ? 15'h4001 : 15'h4002;
                else c = palette[$urandom_range(0, 3)];
                add_req(REQ_WRITE, x, y, c);
            end
        add_req(REQ_FILL, 0, 0, 15'h4003);
        add_req(REQ_FILL, 1, 5, 15'h4004);
        add_req(REQ_READ, 0, 5, 15'd0);
        for (int i = 0; i < 490; i++) begin
            r = $urandom_range(0, 99);
            if (r % 10 == 0) begin
                x = $urandom_range(W-4, W-1);
                y = $urandom_range(H-4, H-1);
            end else begin
                x = $urandom_range(0, WA-1);
                y = $urandom_range(0, HA-1);
            end
            c = ($urandom_range(0, 1) == 0) ? palette[$urandom_range(0, 3)] : 15'($urandom);
            if (c == BORDER) c = 15'd0;
            if (r < 5) begin
                x = $urandom_range(0, 255);
                y = $urandom_range(H, 255);
            end
            if (r < 40) k = REQ_WRITE;
            else if (r < 65) k = REQ_READ;
            else if (r < 95) k = REQ_FILL;
            else k = REQ_UNUSED;
            add_req(k[1:0], x, y, c);
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        do @(posedge aclk);
        while (req_queue.size() != 0 || pending_results.size() != 0 || s_tvalid);
        repeat (50) @(posedge aclk);
        if (fail_cnt == 0 && pending_results.size() == 0) begin
            $display("[span_flood_fill] OK");
        end else begin
            $display("[span_flood_fill] ERROR");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("[span_flood_fill] ERROR");
        $finish;
    end

endmodule
